/* sv/olbpl_pkg.sv */
// Shared constants, state type and the ELVSS code function of the brightness/persistence limiter.
package olbpl_pkg;

    // Default width of the row counts.
    localparam int ROW_BITS_DEF = 12;

    // Lit rows are clamped to total rows minus this margin.
    localparam int LIMIT_OFS = 6;

    // Lower duty threshold 0.2255 as 10000*lit >= 2255*total.
    localparam int LO_LIT = 10000;
    localparam int LO_TOT = 2255;

    // Upper duty threshold 0.3 as 10*lit < 3*total.
    localparam int HI_LIT = 10;
    localparam int HI_TOT = 3;

    // Width of the scaling band in units of 1/10000 of the total rows.
    localparam int SPAN = 745;

    // Rounded multi-duty rows: (6*total + 10) / 20.
    localparam int MULTI_NUM_OFS = 10;
    localparam int MULTI_DEN = 20;

    localparam int BRIGHT_MAX = 255;
    localparam int BRIGHT_BITS = 8;
    localparam int ELVSS_BITS = 5;
    localparam int ELVSS_BASE = 10;
    localparam int ELVSS_STEP = 23;
    localparam int ELVSS_STEPS = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_CLASS,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_DONE
    } state_t;

    // round((255 - b) / 23) + 10, as a count of crossed rounding thresholds.
    function automatic logic [ELVSS_BITS-1:0] elvss_code(input logic [BRIGHT_BITS-1:0] b);
        logic [BRIGHT_BITS-1:0] x;
        logic [ELVSS_BITS-1:0]  cnt;
        x   = BRIGHT_BITS'(BRIGHT_MAX) - b;
        cnt = ELVSS_BITS'(ELVSS_BASE);
        for (int k = 1; k <= ELVSS_STEPS; k++) begin
            if (x >= BRIGHT_BITS'(ELVSS_STEP * k - (ELVSS_STEP / 2))) begin
                cnt = cnt + ELVSS_BITS'(1);
            end
        end
        return cnt;
    endfunction

endpackage

/* sv/olbpl_serdiv.sv */
// Restoring divider that produces one quotient bit per clock cycle.
module olbpl_serdiv #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 23,
    parameter int QUO_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [NUM_W-1:0]   num_sh_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   quo_reg;

    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     trial_diff;
    logic               take;
    logic [DEN_W-1:0]   rem_next;

    // One numerator bit enters the partial remainder each cycle while the divider is busy.
    always_comb begin
        trial      = {rem_reg, num_sh_reg[NUM_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        take       = (trial >= {1'b0, den_reg});
        rem_next   = take ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_sh_reg <= num;
            den_reg    <= den;
            rem_reg    <= '0;
            quo_reg    <= '0;
        end else if (busy_reg) begin
            num_sh_reg <= {num_sh_reg[NUM_W-2:0], 1'b0};
            rem_reg    <= rem_next;
            quo_reg    <= {quo_reg[QUO_W-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* sv/oled_brightness_persistence_limiter.sv */
// Top level of the OLED brightness and persistence current limiter.
//
// One input transaction carries a brightness request together with the rolling-band settings
// and the frame's total rows; one output transaction returns the limited brightness, the lit
// rows, the multi-duty flag, the effective direction, the ELVSS code, the dim-first flag and
// the effective persistence. Requests are handled one at a time. A request whose duty stays
// below 0.2255, or that is zeroed outright, goes from acceptance through the product and
// classification states to a loaded result; a request in the scaling band adds a bit-serial
// multiply of the brightness by the duty excess followed by a restoring divider that retires
// one numerator bit per cycle over ROW_BITS + 19 bits; the multi-duty case uses the same
// divider without the multiply. A new request is taken while a finished result still waits
// in the output register. The last delivered brightness is kept to decide dim_first and is
// zero after reset. All arithmetic is exact with rounding half away from zero.
module oled_brightness_persistence_limiter #(
    parameter int ROW_BITS = olbpl_pkg::ROW_BITS_DEF,
    localparam int IN_W    = ((3 + olbpl_pkg::BRIGHT_BITS + 2 * ROW_BITS + 7) / 8) * 8,
    localparam int OUT_W   = ((3 + olbpl_pkg::BRIGHT_BITS + olbpl_pkg::ELVSS_BITS
                               + 2 * ROW_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From bit 0: rolling enable, rolling reverse, requested lit rows, frame rows,
    // requested brightness, self powered, zero padding.
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0: brightness, lit rows, multiple-band flag, reverse, ELVSS code,
    // dim first, persistence, zero padding.
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int BB      = olbpl_pkg::BRIGHT_BITS;
    localparam int EB      = olbpl_pkg::ELVSS_BITS;

    // Input field offsets.
    localparam int I_REV   = 1;
    localparam int I_LIT   = 2;
    localparam int I_TOT   = I_LIT + ROW_BITS;
    localparam int I_BRI   = I_TOT + ROW_BITS;
    localparam int I_SELF  = I_BRI + BB;

    // Arithmetic widths; each holds the largest value that can reach it.
    localparam int A_W     = ROW_BITS + 14;   // 10000*lit and 2255*total
    localparam int DIFF_W  = ROW_BITS + 10;   // duty excess, below 745*total
    localparam int HI_W    = ROW_BITS + 4;    // 10*lit and 3*total
    localparam int ACC_W   = ROW_BITS + 18;   // brightness times duty excess
    localparam int NUM_W   = ACC_W + 1;       // dividend for the rounded quotient
    localparam int DEN_W   = DIFF_W + 1;      // twice the divisor
    localparam int MCNT_W  = $clog2(BB);

    olbpl_pkg::state_t  state_reg, state_next;

    logic [ROW_BITS-1:0] lit_reg;
    logic [ROW_BITS-1:0] total_reg;
    logic [BB-1:0]       bright_reg;
    logic                self_reg;
    logic                rev_reg;
    logic                multi_reg;
    logic [A_W-1:0]      a_reg;
    logic [A_W-1:0]      c_reg;
    logic [DIFF_W-1:0]   den_reg;
    logic [DIFF_W-1:0]   mcand_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [BB-1:0]       b_sh_reg;
    logic [MCNT_W-1:0]   mcnt_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic [BB-1:0]       last_bright_reg;

    // Input fields.
    logic                in_rolling;
    logic                in_reverse;
    logic [ROW_BITS-1:0] in_lit;
    logic [ROW_BITS-1:0] in_total;
    logic [BB-1:0]       in_bright;
    logic                in_self;
    logic [ROW_BITS-1:0] in_limit;
    logic [ROW_BITS-1:0] lit_clamped;

    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                lo_hit;
    logic                hi_below;
    logic [A_W-1:0]      diff_full;
    logic [ACC_W-1:0]    acc_next;

    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_busy;
    logic                div_done;
    logic [ROW_BITS-1:0] div_quo;

    logic [BB-1:0]       scaled_bright;
    logic [ROW_BITS-1:0] persist;
    logic [EB-1:0]       elvss;
    logic                dim;

    // Unpack the request and apply the lit-row clamp straight away.
    always_comb begin
        in_rolling = s_tdata[0];
        in_reverse = s_tdata[I_REV];
        in_lit     = s_tdata[I_LIT +: ROW_BITS];
        in_total   = s_tdata[I_TOT +: ROW_BITS];
        in_bright  = s_tdata[I_BRI +: BB];
        in_self    = s_tdata[I_SELF];
        // Frames shorter than the margin clamp the lit rows to zero.
        if (in_total >= ROW_BITS'(olbpl_pkg::LIMIT_OFS)) begin
            in_limit = in_total - ROW_BITS'(olbpl_pkg::LIMIT_OFS);
        end else begin
            in_limit = '0;
        end
        if (in_rolling && (in_lit <= in_limit)) begin
            lit_clamped = in_lit;
        end else begin
            lit_clamped = in_limit;
        end
    end

    // Duty classification. A zero-row frame counts as zero duty and is never limited.
    always_comb begin
        lo_hit    = (total_reg != '0) && (a_reg >= c_reg);
        hi_below  = (HI_W'(lit_reg) * HI_W'(olbpl_pkg::HI_LIT))
                  < (HI_W'(total_reg) * HI_W'(olbpl_pkg::HI_TOT));
        diff_full = a_reg - c_reg;
    end

    // Shift-and-add multiply, brightness most significant bit first.
    always_comb begin
        acc_next = {acc_reg[ACC_W-2:0], 1'b0};
        if (b_sh_reg[BB-1]) begin
            acc_next = acc_next + ACC_W'(mcand_reg);
        end
    end

    // Divider operands. Scaling: (2*num + den) / (2*den). Multi-duty: (6*total + 10) / 20.
    always_comb begin
        if (multi_reg) begin
            div_num = NUM_W'({total_reg, 2'b00}) + NUM_W'({total_reg, 1'b0})
                    + NUM_W'(olbpl_pkg::MULTI_NUM_OFS);
            div_den = DEN_W'(olbpl_pkg::MULTI_DEN);
        end else begin
            div_num = {acc_reg, 1'b0} + NUM_W'(den_reg);
            div_den = {den_reg, 1'b0};
        end
    end

    // The rounded reduction never exceeds 255 in the scaling band; saturate anyway.
    always_comb begin
        if (div_quo >= ROW_BITS'(olbpl_pkg::BRIGHT_MAX)) begin
            scaled_bright = '0;
        end else begin
            scaled_bright = BB'(ROW_BITS'(olbpl_pkg::BRIGHT_MAX) - div_quo);
        end
    end

    olbpl_serdiv #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (ROW_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            olbpl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = olbpl_pkg::ST_PROD;
                end
            end
            olbpl_pkg::ST_PROD: begin
                state_next = olbpl_pkg::ST_CLASS;
            end
            olbpl_pkg::ST_CLASS: begin
                priority if (!lo_hit) begin
                    state_next = olbpl_pkg::ST_DONE;
                end else if (hi_below) begin
                    state_next = olbpl_pkg::ST_MUL;
                end else if (self_reg) begin
                    state_next = olbpl_pkg::ST_DONE;
                end else begin
                    state_next = olbpl_pkg::ST_DSTART;
                end
            end
            olbpl_pkg::ST_MUL: begin
                if (mcnt_reg == MCNT_W'(BB - 1)) begin
                    state_next = olbpl_pkg::ST_DSTART;
                end
            end
            olbpl_pkg::ST_DSTART: begin
                state_next = olbpl_pkg::ST_DIV;
            end
            olbpl_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = olbpl_pkg::ST_DONE;
                end
            end
            olbpl_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = olbpl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = olbpl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        out_free  = !m_tvalid_reg || m_tready;
        s_tready  = (state_reg == olbpl_pkg::ST_IDLE);
        in_accept = s_tvalid && s_tready;
        div_start = (state_reg == olbpl_pkg::ST_DSTART);
        out_load  = (state_reg == olbpl_pkg::ST_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= olbpl_pkg::ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            last_bright_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg    <= 1'b1;
                last_bright_reg <= bright_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, loaded according to the sequencer state.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            olbpl_pkg::ST_IDLE: begin
                if (in_accept) begin
                    lit_reg    <= lit_clamped;
                    total_reg  <= in_total;
                    bright_reg <= in_bright;
                    self_reg   <= in_self;
                    rev_reg    <= in_rolling && in_reverse;
                    multi_reg  <= 1'b0;
                end
            end
            olbpl_pkg::ST_PROD: begin
                a_reg   <= A_W'(lit_reg) * A_W'(olbpl_pkg::LO_LIT);
                c_reg   <= A_W'(total_reg) * A_W'(olbpl_pkg::LO_TOT);
                den_reg <= DIFF_W'(total_reg) * DIFF_W'(olbpl_pkg::SPAN);
            end
            olbpl_pkg::ST_CLASS: begin
                if (lo_hit) begin
                    if (hi_below) begin
                        mcand_reg <= diff_full[DIFF_W-1:0];
                        b_sh_reg  <= bright_reg;
                        acc_reg   <= '0;
                        mcnt_reg  <= '0;
                    end else begin
                        bright_reg <= '0;
                        multi_reg  <= !self_reg;
                    end
                end
            end
            olbpl_pkg::ST_MUL: begin
                acc_reg  <= acc_next;
                b_sh_reg <= {b_sh_reg[BB-2:0], 1'b0};
                mcnt_reg <= mcnt_reg + MCNT_W'(1);
            end
            olbpl_pkg::ST_DIV: begin
                if (div_done) begin
                    if (multi_reg) begin
                        lit_reg <= div_quo;
                    end else begin
                        bright_reg <= scaled_bright;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result assembly.
    always_comb begin
        persist = multi_reg ? total_reg : lit_reg;
        elvss   = olbpl_pkg::elvss_code(bright_reg);
        dim     = (bright_reg < last_bright_reg);
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= OUT_W'({persist, dim, elvss, rev_reg, multi_reg, lit_reg, bright_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The divider is only ever running while a request is in the arithmetic phase.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("divider busy while the block is ready for a request");

    // A new request closes the input side on the following cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("input accepted twice in a row");

    // Multi-duty always comes with zero brightness.
    a_multi_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[BB + ROW_BITS]) |-> (m_tdata[BB-1:0] == '0))
        else $error("multi-duty result with non-zero brightness");

    // The ELVSS code stays within its legal range.
    a_elvss_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[BB + ROW_BITS + 2 +: EB] >= EB'(olbpl_pkg::ELVSS_BASE))
                   && (m_tdata[BB + ROW_BITS + 2 +: EB]
                       <= EB'(olbpl_pkg::ELVSS_BASE + olbpl_pkg::ELVSS_STEPS))))
        else $error("ELVSS code out of range");

endmodule
